@@ rtl/wap_push_header_parser_assert.svh @@
// Assertion macros shared by the parser blocks.
// Each macro takes a label, the clock, the active-low reset, a condition,
// a consequence and a message.
`ifndef WAP_PUSH_HEADER_PARSER_ASSERT_SVH
`define WAP_PUSH_HEADER_PARSER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define WAP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define WAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wap_pkg.sv @@
// ----------------------------------------------------------------------------
// WAP push header parser package
// Types, codes and constants shared by the parser, the result queue and the
// top level.
// ----------------------------------------------------------------------------
package wap_pkg;

    // Default parameter values.
    localparam int MAX_UINTVAR_BYTES_DEF = 5;
    localparam int BODY_COUNT_BITS_DEF   = 16;

    // Protocol byte values.
    localparam logic [7:0] PDU_TYPE_PUSH   = 8'h06;
    localparam logic [7:0] CT_VALUE_LENGTH = 8'h1F;
    localparam logic [7:0] CT_PROVISIONING = 8'hB6;
    localparam logic [7:0] PARAM_SEC       = 8'h91;
    localparam logic [7:0] PARAM_MAC       = 8'h92;
    localparam logic [7:0] UV_CONT_BIT     = 8'h80;
    localparam logic [7:0] UV_DATA_MASK    = 8'h7F;
    localparam logic [7:0] SEC_BIAS        = 8'h80;
    localparam logic [7:0] MAC_TERMINATOR  = 8'h00;

    // Widths.
    localparam int UV_ACCUM_W   = 32;
    localparam int UV_BYTES_W   = 3;
    localparam int BODY_LEN_W   = 16;
    localparam logic [BODY_LEN_W-1:0] BODY_LEN_MAX = '1;

    // Result queue geometry: room for two items from one input byte.
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    // Parse phases.
    typedef enum logic [3:0] {
        PH_TID,
        PH_PDU,
        PH_HLEN,
        PH_CTSEL,
        PH_CTVL,
        PH_SHORTLEN,
        PH_CONTENT,
        PH_PARAM1,
        PH_SEC,
        PH_PARAM2,
        PH_MAC,
        PH_BODY
    } t_phase;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_MAC,
        KIND_BODY,
        KIND_SUMMARY,
        KIND_ERROR
    } t_kind;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BAD_PDU,
        ERR_UINTVAR_LONG,
        ERR_BAD_CONTENT,
        ERR_SEC_SHORT,
        ERR_TRUNCATED
    } t_err;

    // One result item.
    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            data_byte;
        logic                  sec_present;
        logic signed [7:0]     sec_value;
        t_err                  error_code;
        logic [BODY_LEN_W-1:0] body_length;
        logic                  last;
    } t_result;

    // Up to two result items produced by one input byte, in order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

@@ rtl/wap_parser.sv @@
// ----------------------------------------------------------------------------
// WAP push parser core
// Input register, parse state and the per-byte step logic. Each processed
// byte yields up to two result items for the result queue.
// ----------------------------------------------------------------------------
module wap_parser #(
    parameter int MAX_UINTVAR_BYTES = wap_pkg::MAX_UINTVAR_BYTES_DEF,
    parameter int BODY_COUNT_BITS   = wap_pkg::BODY_COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_message,
    input  logic          i_room,
    output wap_pkg::t_push o_push
);
    import wap_pkg::*;

    `include "wap_push_header_parser_assert.svh"

    // Input register.
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eom;

    // Parse state.
    t_phase                    r_phase, n_phase;
    logic [UV_ACCUM_W-1:0]     r_accum, n_accum;
    logic [UV_BYTES_W-1:0]     r_uv_bytes, n_uv_bytes;
    logic [UV_ACCUM_W-1:0]     r_params, n_params;
    logic                      r_sec_seen, n_sec_seen;
    logic [7:0]                r_sec_byte, n_sec_byte;
    logic [BODY_COUNT_BITS-1:0] r_body_count, n_body_count;
    logic                      r_error_seen, n_error_seen;

    // Values after one step, before the end-of-message re-arm.
    t_phase                    s_phase;
    logic [UV_ACCUM_W-1:0]     s_accum;
    logic [UV_BYTES_W-1:0]     s_uv_bytes;
    logic [UV_ACCUM_W-1:0]     s_params;
    logic                      s_sec_seen;
    logic [7:0]                s_sec_byte;
    logic [BODY_COUNT_BITS-1:0] s_body_count;
    t_err                      s_err;
    logic                      s_data_valid;
    t_kind                     s_data_kind;

    logic                      proc;
    logic [7:0]                b;
    logic                      eom;
    logic                      uv_cont;
    logic [UV_BYTES_W-1:0]     uv_bytes_inc;
    logic [UV_ACCUM_W-1:0]     uv_or;
    logic [UV_ACCUM_W-1:0]     uv_shift;
    logic                      uv_long;
    logic [BODY_COUNT_BITS-1:0] body_inc;
    logic [BODY_LEN_W-1:0]     body_len_sat;
    logic [UV_ACCUM_W-1:0]     params_less2;
    t_result                   res_data, res_final;
    logic                      final_valid;

    // The held byte is processed once the result queue can take two items.
    assign proc    = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign b       = r_in_byte;
    assign eom     = r_in_eom;

    assign n_in_valid = o_stall ? r_in_valid : i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_in_byte;
            r_in_eom  <= i_end_of_message;
        end
    end

    // Uintvar decode of the current byte.
    assign uv_cont      = (b & UV_CONT_BIT) != 8'd0;
    assign uv_bytes_inc = r_uv_bytes + UV_BYTES_W'(1);
    assign uv_or        = r_accum | {24'd0, b & UV_DATA_MASK};
    assign uv_shift     = {uv_or[UV_ACCUM_W-8:0], 7'd0};
    assign uv_long      = uv_bytes_inc >= UV_BYTES_W'(MAX_UINTVAR_BYTES);

    // Saturating body counter and clipped summary length.
    assign body_inc = (r_body_count == '1) ? r_body_count
                                           : r_body_count + BODY_COUNT_BITS'(1);
    assign body_len_sat = (32'(s_body_count) > 32'(BODY_LEN_MAX)) ? BODY_LEN_MAX
                                                                 : BODY_LEN_W'(s_body_count);
    assign params_less2 = r_params - UV_ACCUM_W'(2);

    // One step of the parse for the held byte.
    always_comb begin
        s_phase      = r_phase;
        s_accum      = r_accum;
        s_uv_bytes   = r_uv_bytes;
        s_params     = r_params;
        s_sec_seen   = r_sec_seen;
        s_sec_byte   = r_sec_byte;
        s_body_count = r_body_count;
        s_err        = ERR_NONE;
        s_data_valid = 1'b0;
        s_data_kind  = KIND_BODY;
        case (r_phase)
            PH_TID: begin
                s_phase = PH_PDU;
            end
            PH_PDU: begin
                if (b != PDU_TYPE_PUSH) begin
                    s_err = ERR_BAD_PDU;
                end else begin
                    s_phase = PH_HLEN;
                end
            end
            PH_HLEN: begin
                if (uv_cont) begin
                    s_uv_bytes = uv_bytes_inc;
                    s_accum    = uv_shift;
                    if (uv_long) begin
                        s_err = ERR_UINTVAR_LONG;
                    end
                end else begin
                    if (uv_or > UV_ACCUM_W'(1)) begin
                        s_phase = PH_CTSEL;
                    end else begin
                        s_params = '0;
                        s_phase  = PH_CONTENT;
                    end
                    s_accum    = '0;
                    s_uv_bytes = '0;
                end
            end
            PH_CTSEL: begin
                s_phase = (b == CT_VALUE_LENGTH) ? PH_CTVL : PH_SHORTLEN;
            end
            PH_CTVL: begin
                if (uv_cont) begin
                    s_uv_bytes = uv_bytes_inc;
                    s_accum    = uv_shift;
                    if (uv_long) begin
                        s_err = ERR_UINTVAR_LONG;
                    end
                end else begin
                    s_params   = uv_or - UV_ACCUM_W'(1);
                    s_accum    = '0;
                    s_uv_bytes = '0;
                    s_phase    = PH_CONTENT;
                end
            end
            PH_SHORTLEN: begin
                s_params = {24'd0, b & UV_DATA_MASK} - UV_ACCUM_W'(1);
                s_phase  = PH_CONTENT;
            end
            PH_CONTENT: begin
                if (b != CT_PROVISIONING) begin
                    s_err = ERR_BAD_CONTENT;
                end else begin
                    s_phase = (r_params != '0) ? PH_PARAM1 : PH_BODY;
                end
            end
            PH_PARAM1: begin
                if (b == PARAM_SEC) begin
                    if (r_params < UV_ACCUM_W'(2)) begin
                        s_err = ERR_SEC_SHORT;
                    end else begin
                        s_phase = PH_SEC;
                    end
                end else if (b == PARAM_MAC) begin
                    s_phase = PH_MAC;
                end else begin
                    s_data_valid = 1'b1;
                    s_body_count = body_inc;
                    s_phase      = PH_BODY;
                end
            end
            PH_SEC: begin
                s_sec_seen = 1'b1;
                s_sec_byte = b;
                s_params   = params_less2;
                s_phase    = (params_less2 != '0) ? PH_PARAM2 : PH_BODY;
            end
            PH_PARAM2: begin
                if (b == PARAM_MAC) begin
                    s_phase = PH_MAC;
                end else begin
                    s_data_valid = 1'b1;
                    s_body_count = body_inc;
                    s_phase      = PH_BODY;
                end
            end
            PH_MAC: begin
                if (b == MAC_TERMINATOR) begin
                    s_phase = PH_BODY;
                end else begin
                    s_data_valid = 1'b1;
                    s_data_kind  = KIND_MAC;
                end
            end
            default: begin
                s_data_valid = 1'b1;
                s_body_count = body_inc;
                s_phase      = PH_BODY;
            end
        endcase
    end

    // Result items for the held byte.
    always_comb begin
        res_data             = '0;
        res_data.kind        = s_data_kind;
        res_data.data_byte   = b;
        res_data.error_code  = ERR_NONE;

        res_final            = '0;
        res_final.last       = 1'b1;
        if (s_err != ERR_NONE) begin
            res_final.kind       = KIND_ERROR;
            res_final.error_code = s_err;
        end else if (s_phase inside {PH_PARAM1, PH_PARAM2, PH_BODY}) begin
            res_final.kind        = KIND_SUMMARY;
            res_final.error_code  = ERR_NONE;
            res_final.sec_present = s_sec_seen;
            res_final.sec_value   = s_sec_seen ? $signed(s_sec_byte ^ SEC_BIAS) : 8'sd0;
            res_final.body_length = body_len_sat;
        end else begin
            res_final.kind       = KIND_ERROR;
            res_final.error_code = ERR_TRUNCATED;
        end
        final_valid = (s_err != ERR_NONE) || eom;

        o_push = '0;
        if (proc && !r_error_seen) begin
            if (s_data_valid) begin
                o_push.first  = res_data;
                o_push.second = res_final;
                o_push.cnt    = final_valid ? 2'd2 : 2'd1;
            end else begin
                o_push.first  = res_final;
                o_push.cnt    = final_valid ? 2'd1 : 2'd0;
            end
        end
    end

    // Next state: take the step, then re-arm at the end of a message.
    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_uv_bytes   = r_uv_bytes;
        n_params     = r_params;
        n_sec_seen   = r_sec_seen;
        n_sec_byte   = r_sec_byte;
        n_body_count = r_body_count;
        n_error_seen = r_error_seen;
        if (proc) begin
            if (!r_error_seen) begin
                n_phase      = s_phase;
                n_accum      = s_accum;
                n_uv_bytes   = s_uv_bytes;
                n_params     = s_params;
                n_sec_seen   = s_sec_seen;
                n_sec_byte   = s_sec_byte;
                n_body_count = s_body_count;
                n_error_seen = (s_err != ERR_NONE);
            end
            if (eom) begin
                n_phase      = PH_TID;
                n_accum      = '0;
                n_uv_bytes   = '0;
                n_params     = '0;
                n_sec_seen   = 1'b0;
                n_sec_byte   = '0;
                n_body_count = '0;
                n_error_seen = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TID;
            r_accum      <= '0;
            r_uv_bytes   <= '0;
            r_params     <= '0;
            r_sec_seen   <= 1'b0;
            r_sec_byte   <= '0;
            r_body_count <= '0;
            r_error_seen <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_accum      <= n_accum;
            r_uv_bytes   <= n_uv_bytes;
            r_params     <= n_params;
            r_sec_seen   <= n_sec_seen;
            r_sec_byte   <= n_sec_byte;
            r_body_count <= n_body_count;
            r_error_seen <= n_error_seen;
        end
    end

    // Bytes after an error give no items until the message ends.
    `WAP_ASSERT_SAME(a_quiet_after_error, i_clk, i_rst_n, proc && r_error_seen,
        o_push.cnt == 2'd0, "item produced after an error")
    // The body count only moves when a byte is processed.
    `WAP_ASSERT_NEXT(a_count_held, i_clk, i_rst_n, !proc, $stable(r_body_count),
        "body count changed without a byte")
    // The end of a message re-arms the parser.
    `WAP_ASSERT_NEXT(a_rearm, i_clk, i_rst_n, proc && r_in_eom,
        r_phase == PH_TID && !r_error_seen, "parser not re-armed after message end")

endmodule

@@ rtl/wap_res_fifo.sv @@
// ----------------------------------------------------------------------------
// WAP push result queue
// Small register queue that takes up to two result items per cycle and
// presents one item per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module wap_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wap_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_stall,
    output wap_pkg::t_result o_item
);
    import wap_pkg::*;

    `include "wap_push_header_parser_assert.svh"

    t_result               r_mem [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0]  r_wr, n_wr;
    logic [RES_PTR_W-1:0]  r_rd, n_rd;
    logic [RES_CNT_W-1:0]  r_count, n_count;
    logic [RES_PTR_W-1:0]  wr_second;
    logic                  pop;

    // Room for a full pair of items from one byte.
    assign o_room  = r_count <= RES_CNT_W'(RES_FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;

    assign wr_second = r_wr + RES_PTR_W'(1);
    assign n_wr      = r_wr + RES_PTR_W'(i_push.cnt);
    assign n_rd      = r_rd + RES_PTR_W'(pop);
    assign n_count   = r_count + RES_CNT_W'(i_push.cnt) - RES_CNT_W'(pop);

    // Storage writes, the first item of a pair in order before the second.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_second] <= i_push.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `WAP_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push.cnt != 2'd0,
        o_room, "push into a queue without room")
    `WAP_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= RES_CNT_W'(RES_FIFO_DEPTH), "queue count beyond depth")
    `WAP_ASSERT_NEXT(a_pair_count, i_clk, i_rst_n, i_push.cnt == 2'd2 && !pop,
        r_count == $past(r_count) + RES_CNT_W'(2), "pair push miscounted")

endmodule

@@ rtl/wap_push_header_parser.sv @@
// ----------------------------------------------------------------------------
// WAP push header parser
// Parses a push message one byte per item: transaction id, PDU type, header
// and content-type lengths, content type, SEC and MAC parameters, and body.
// MAC and body bytes are passed on as they arrive; a summary or error item
// closes each message.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   i_in_byte, i_end_of_message
//  output   out        o_valid / i_stall   o_kind, o_data_byte, o_sec_present,
//                                          o_sec_value, o_error_code,
//                                          o_body_length, o_last
//
//  One input byte per clock is taken while each byte yields at most one item
//  and the output is not stalled; a byte that yields two items leaves one more
//  item in the result queue, whose single-item output port drains one at a time.
//  An item passes the input register and the result queue before it is presented.
//  Reset is synchronous and active low; it re-arms the parser for a new message.
//  An output stall lets the four-entry result queue fill; once it holds three
//  or more items, a held byte stalls the input.
// ----------------------------------------------------------------------------
module wap_push_header_parser #(
    parameter int MAX_UINTVAR_BYTES = wap_pkg::MAX_UINTVAR_BYTES_DEF,
    parameter int BODY_COUNT_BITS   = wap_pkg::BODY_COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_end_of_message,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_data_byte,
    output logic                         o_sec_present,
    output logic signed [7:0]            o_sec_value,
    output logic [2:0]                   o_error_code,
    output logic [wap_pkg::BODY_LEN_W-1:0] o_body_length,
    output logic                         o_last
);
    import wap_pkg::*;

    t_push   push;
    t_result item;
    logic    room;

    // Parse state and step logic.
    wap_parser #(
        .MAX_UINTVAR_BYTES (MAX_UINTVAR_BYTES),
        .BODY_COUNT_BITS   (BODY_COUNT_BITS)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .i_room           (room),
        .o_push           (push)
    );

    // Result queue feeding the output channel.
    wap_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (item)
    );

    // Unpack the head item onto the output fields.
    assign o_kind        = item.kind;
    assign o_data_byte   = item.data_byte;
    assign o_sec_present = item.sec_present;
    assign o_sec_value   = item.sec_value;
    assign o_error_code  = item.error_code;
    assign o_body_length = item.body_length;
    assign o_last        = item.last;

endmodule
